// ----- sv/pal_pkg.sv -----
// pal_pkg: opcodes, sequencer states and the broadcast command for the list cells
// no dependencies; used by pal_cell, positional_array_list and the bench

package pal_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 6;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_PICK
  } st_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;   // shift up from the target and write the new word
    logic del;   // shift down onto the target
    logic cmp;   // register the key compare
    logic clr;   // drop the compare flags
  } cell_cmd_t;

endpackage

// ----- sv/pal_cell.sv -----
// pal_cell: one list slot, holds a word, shifts with its neighbors, compares the key
// depends on pal_pkg

module pal_cell
  import pal_pkg::*;
#(
  parameter int unsigned CntW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [CntW-1:0]         tgt_i,
  input  logic [CntW-1:0]         cnt_i,
  input  logic signed [WordW-1:0] val_i,
  input  logic signed [WordW-1:0] left_i,
  input  logic signed [WordW-1:0] right_i,
  output logic signed [WordW-1:0] data_o,
  output logic signed [WordW-1:0] sel_o,
  output logic                    hit_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic signed [WordW-1:0] data_q, data_d;
  logic                    hit_q, hit_d;
  logic                    occupied;
  logic                    is_tgt;

  assign occupied = MyIdx < cnt_i;
  assign is_tgt   = MyIdx == tgt_i;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (is_tgt) begin
        data_d = val_i;
      end else if (MyIdx > tgt_i && MyIdx <= cnt_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= tgt_i) begin
        data_d = right_i;
      end
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.cmp) begin
      hit_d = occupied && (data_q == val_i);
    end else if (cmd_i.clr) begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

  assign data_o = data_q;
  assign sel_o  = is_tgt ? data_q : '0;
  assign hit_o  = hit_q;

endmodule

// ----- sv/pal_first.sv -----
// pal_first: picks the lowest set compare flag and turns it into a 1-based position
// depends on nothing outside this file

module pal_first #(
  parameter int unsigned Depth = 32,
  parameter int unsigned CntW  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pick_i,
  input  logic [Depth-1:0]  hit_i,
  output logic [CntW-1:0]   found_o
);

  logic [Depth-1:0] first_q, first_d;

  // isolate the lowest set bit
  assign first_d = hit_i & (~hit_i + Depth'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
    end else if (pick_i) begin
      first_q <= first_d;
    end
  end

  always_comb begin
    found_o = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first_q[i]) begin
        found_o = found_o | CntW'(i + 1);
      end
    end
  end

endmodule

// ----- sv/positional_array_list.sv -----
// positional_array_list: bounded 1-based list of signed words kept in a row of shifting cells
// depends on pal_pkg, pal_cell, pal_first
//
//   channel  | valid       | stall       | fields
//   ---------+-------------+-------------+------------------------------------------------
//   in       | in_valid_i  | in_stall_o  | opcode_i, position_i, value_in_i
//   out      | out_valid_o | out_stall_i | status_o, value_out_o, found_position_o,
//            |             |             | count_o, is_empty_o
//
// insert, delete, get, clear and unused opcodes load the result directly: every cell decides
// its own shift from its index and the target, and the read word is or-ed out of the row
// locate steps through a registered compare in every cell, lowest-flag pick, position encode
// the input stalls during a locate and while a finished result is held by out_stall_i
// reset empties the list; the words in the cells are not cleared and are never read

module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              opcode_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [WordW-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    status_o,
  output logic signed [WordW-1:0] value_out_o,
  output logic [PosW-1:0]         found_position_o,
  output logic [PosW-1:0]         count_o,
  output logic                    is_empty_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  st_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic            in_acc;
  logic            out_free;
  logic            pick_en;
  logic            found_load;

  logic [CmpW-1:0] pos_w, cnt_w;
  logic            ins_ok, rd_ok;
  logic [CntW-1:0] tgt;
  op_e             op;

  cell_cmd_t               cmd;
  logic signed [WordW-1:0] cell_data [DEPTH];
  logic signed [WordW-1:0] cell_sel  [DEPTH];
  logic [DEPTH-1:0]        hits;
  logic signed [WordW-1:0] rd_word;
  logic [CntW-1:0]         found;

  logic                    out_valid_q;
  logic                    status_q, status_d;
  logic signed [WordW-1:0] vout_q, vout_d;
  logic [CntW-1:0]         fpos_q, fpos_d;
  logic                    load_direct;

  assign op       = op_e'(opcode_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign pos_w  = CmpW'(position_i);
  assign cnt_w  = CmpW'(count_q);
  assign ins_ok = (cnt_w < CmpW'(DEPTH)) && (pos_w != '0) && (pos_w <= cnt_w + CmpW'(1));
  assign rd_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign tgt    = CntW'(pos_w - CmpW'(1));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_LOCATE) begin
          state_d = ST_HIT;
        end
      end
      ST_HIT:  state_d = ST_PICK;
      ST_PICK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    pick_en    = 1'b0;
    found_load = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = !out_free;
      ST_HIT:  pick_en    = 1'b1;
      ST_PICK: found_load = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-operation decode
  always_comb begin
    cmd         = '0;
    count_d     = count_q;
    status_d    = 1'b0;
    vout_d      = '0;
    fpos_d      = '0;
    load_direct = 1'b0;
    if (in_acc) begin
      load_direct = 1'b1;
      case (op)
        OP_INSERT: begin
          status_d = !ins_ok;
          if (ins_ok) begin
            cmd.ins = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OP_DELETE: begin
          status_d = !rd_ok;
          if (rd_ok) begin
            cmd.del = 1'b1;
            vout_d  = rd_word;
            count_d = count_q - CntW'(1);
          end
        end
        OP_GET: begin
          status_d = !rd_ok;
          if (rd_ok) begin
            vout_d = rd_word;
          end
        end
        OP_LOCATE: begin
          cmd.cmp     = 1'b1;
          load_direct = 1'b0;
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = 1'b1;
        end
      endcase
    end else if (found_load) begin
      cmd.clr = 1'b1;
      fpos_d  = found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .tgt_i   (tgt),
      .cnt_i   (count_q),
      .val_i   (value_in_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .sel_o   (cell_sel[i]),
      .hit_o   (hits[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_sel[i];
    end
  end

  pal_first #(
    .Depth (DEPTH),
    .CntW  (CntW)
  ) u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pick_i  (pick_en),
    .hit_i   (hits),
    .found_o (found)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_direct || found_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct || found_load) begin
      status_q <= status_d;
      vout_q   <= vout_d;
      fpos_q   <= fpos_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign value_out_o      = vout_q;
  assign found_position_o = PosW'(fpos_q);
  assign count_o          = PosW'(count_q);
  assign is_empty_o       = count_q == '0;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("list length beyond depth");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("input open during locate");

  a_pick_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PICK |-> !out_valid_q)
    else $error("locate result would overwrite a held beat");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del |=> count_q == $past(count_q) - CntW'(1))
    else $error("delete did not shrink the list");

endmodule

// ----- tb/positional_array_list_tb.sv -----
// positional_array_list_tb: self-checking bench for the positional array list
// needs pal_pkg and positional_array_list; tracks the list contents and checks every result beat

module positional_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int Depth      = 32;
  localparam int HoldCycles = 300;
  localparam int RandBeats  = 1825;

  typedef struct packed {
    logic                    status;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         found;
    logic [PosW-1:0]         count;
    logic                    empty;
  } list_result_t;

  class list_tracker;
    logic signed [WordW-1:0] words [Depth];
    int unsigned             len;
    list_result_t            pending [$];
    int unsigned             mismatches;

    function new();
      len        = 0;
      mismatches = 0;
    endfunction

    // applies one operation to the tracked list and returns what the block must answer
    function list_result_t apply_op(logic [2:0] op, logic [PosW-1:0] pos,
                                    logic signed [WordW-1:0] val);
      list_result_t r;
      int           k;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (len >= Depth || pos < 1 || pos > len + 1) begin
            r.status = 1'b1;
          end else begin
            for (k = len; k >= pos; k--) words[k] = words[k-1];
            words[pos-1] = val;
            len++;
          end
        end
        OP_DELETE: begin
          if (len == 0 || pos < 1 || pos > len) begin
            r.status = 1'b1;
          end else begin
            r.value = words[pos-1];
            for (k = pos; k < len; k++) words[k-1] = words[k];
            len--;
          end
        end
        OP_GET: begin
          if (len == 0 || pos < 1 || pos > len) r.status = 1'b1;
          else r.value = words[pos-1];
        end
        OP_LOCATE: begin
          // first match wins
          for (k = 0; k < len; k++) begin
            if (words[k] == val) begin
              r.found = PosW'(k + 1);
              break;
            end
          end
        end
        OP_CLEAR: begin
          len = 0;
        end
        default: begin
          r.status = 1'b1;
        end
      endcase
      r.count = PosW'(len);
      r.empty = (len == 0);
      return r;
    endfunction

    function void note_beat(logic [2:0] op, logic [PosW-1:0] pos, logic signed [WordW-1:0] val);
      pending.push_back(apply_op(op, pos, val));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      end
    endfunction

    function void check_beat(logic status, logic signed [WordW-1:0] value, logic [PosW-1:0] found,
                             logic [PosW-1:0] count, logic empty);
      list_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t result beat with nothing outstanding", $realtime);
        return;
      end
      want = pending.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("value_out", want.value, value);
      compare_field("found_position", 32'(want.found), 32'(found));
      compare_field("count", 32'(want.count), 32'(count));
      compare_field("is_empty", 32'(want.empty), 32'(empty));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [2:0]              opcode_i;
  logic [PosW-1:0]         position_i;
  logic signed [WordW-1:0] value_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    status_o;
  logic signed [WordW-1:0] value_out_o;
  logic [PosW-1:0]         found_position_o;
  logic [PosW-1:0]         count_o;
  logic                    is_empty_o;

  list_tracker tracker;
  bit          calm;
  bit          hold_req;

  positional_array_list #(
    .DEPTH(Depth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .position_i      (position_i),
    .value_in_i      (value_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .value_out_o     (value_out_o),
    .found_position_o(found_position_o),
    .count_o         (count_o),
    .is_empty_o      (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // both channels observed at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o && !out_stall_i)
        tracker.check_beat(status_o, value_out_o, found_position_o, count_o, is_empty_o);
      if (in_valid_i && !in_stall_o)
        tracker.note_beat(opcode_i, position_i, value_in_i);
    end
  end

  // result side stalls at random, plus one long hold-off on request
  initial begin
    int held;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        held     = 0;
        while (held < HoldCycles) begin
          out_stall_i <= 1'b1;
          held++;
          @(negedge clk_i);
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 9);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [2:0] op, input logic [PosW-1:0] pos,
                           input logic signed [WordW-1:0] val);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_in_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned             len;
    int unsigned             pick;
    bit                      growing;
    logic [2:0]              op;
    logic [PosW-1:0]         pos;
    logic signed [WordW-1:0] val;

    tracker    = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_CLEAR;
    position_i = '0;
    value_in_i = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    growing    = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, bad positions, extremes, head/middle/tail inserts, duplicates
    send_beat(OP_GET,    6'd1,  32'sd0);
    send_beat(OP_DELETE, 6'd1,  32'sd0);
    send_beat(OP_LOCATE, 6'd0,  32'sd0);
    send_beat(OP_INSERT, 6'd0,  32'sd5);
    send_beat(OP_INSERT, 6'd2,  32'sd5);
    send_beat(OP_INSERT, 6'd1,  32'sh7fffffff);
    send_beat(OP_INSERT, 6'd1,  32'sh80000000);
    send_beat(OP_INSERT, 6'd3,  32'shffffffff);
    send_beat(OP_INSERT, 6'd2,  32'sd0);
    send_beat(OP_INSERT, 6'd2,  32'sd0);
    send_beat(OP_LOCATE, 6'd0,  32'sd0);
    send_beat(OP_LOCATE, 6'd63, 32'sh7fffffff);
    send_beat(OP_LOCATE, 6'd1,  32'sd12345);
    send_beat(OP_GET,    6'd5,  32'sd0);
    send_beat(OP_GET,    6'd6,  32'sd0);
    send_beat(OP_GET,    6'd63, 32'sd0);
    send_beat(OP_DELETE, 6'd0,  32'sd0);
    send_beat(OP_DELETE, 6'd6,  32'sd0);
    send_beat(OP_DELETE, 6'd3,  32'sd0);
    send_beat(OP_DELETE, 6'd1,  32'sd0);
    send_beat(3'd5,      6'd1,  32'sd1);
    send_beat(3'd6,      6'd1,  32'sd1);
    send_beat(3'd7,      6'd1,  32'sd1);
    send_beat(OP_CLEAR,  6'd0,  32'sd0);
    send_beat(OP_GET,    6'd1,  32'sd0);

    // random part swings the length between empty and full
    for (int i = 0; i < RandBeats; i++) begin
      if (i == 200) hold_req = 1'b1;
      calm = (i >= 900 && i < 1250);
      len  = tracker.len;
      if (len == Depth) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      pick = $urandom_range(999);
      if (pick < 5) op = OP_CLEAR;
      else if (pick < 25) op = 3'($urandom_range(7, 5));
      else if (pick < 200) op = OP_LOCATE;
      else if (pick < 340) op = OP_GET;
      else if (pick < 780) op = growing ? OP_INSERT : OP_DELETE;
      else op = growing ? OP_DELETE : OP_INSERT;

      if ($urandom_range(9) == 0) pos = PosW'($urandom_range(63));
      else if (op == OP_INSERT) pos = PosW'($urandom_range(len + 1, 1));
      else pos = PosW'($urandom_range((len == 0) ? 1 : len, 1));

      // reuse stored words so locate hits and duplicates show up
      if (len > 0 && $urandom_range(2) == 0) val = tracker.words[$urandom_range(len - 1)];
      else val = $urandom();

      send_beat(op, pos, val);
    end
    in_valid_i <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pal_pkg.sv
sv/pal_cell.sv
sv/pal_first.sv
sv/positional_array_list.sv
tb/positional_array_list_tb.sv
